[src/x2luv_pkg.sv]
// shared constants and result type for the xyz to cieluv converter
package x2luv_pkg;

    // field widths
    localparam int XW    = 18;
    localparam int LW    = 16;
    localparam int PW    = 18;
    localparam int SW    = 23;
    localparam int DEN_W = 23;
    localparam int NUM_W = 38;

    // pipeline depths
    localparam int CBRT_STAGES = 21;
    localparam int DIV_QW      = 21;
    localparam int LIGHT_LAT   = CBRT_STAGES + 2;
    localparam int DIV_EXTRA   = LIGHT_LAT - DIV_QW;
    localparam int STAR_LAT    = 4;
    localparam int PIPE_LAT    = LIGHT_LAT + STAR_LAT;

    // lightness constants
    localparam logic [32:0] LIN_MUL    = 33'd24389;
    localparam logic [32:0] LIN_RND    = 33'd3456;
    localparam logic [32:0] LIN_THRESH = 33'd14155776;
    localparam logic [16:0] RECIP27    = 17'd77673;
    localparam int          RECIP27_SH = 21;
    localparam logic [27:0] L_OFF      = 28'd16777216;

    // opponent constants
    localparam logic [25:0] WHITE_U    = 26'd262144;
    localparam logic [25:0] WHITE_V    = 26'd589824;
    localparam logic [45:0] STAR_RND   = 46'd622592;
    localparam logic [28:0] RECIP19    = 29'd452101821;
    localparam int          RECIP19_SH = 33;
    localparam logic [25:0] STAR_POS   = 26'd4194303;
    localparam logic [25:0] STAR_NEG   = 26'd4194304;

    // one converted sample
    typedef struct packed {
        logic [LW-1:0] lightness;
        logic [PW-1:0] u_prime;
        logic [PW-1:0] v_prime;
        logic [SW-1:0] u_star;
        logic [SW-1:0] v_star;
        logic          denom_zero;
    } luv_t;

endpackage

[src/x2luv_div.sv]
// pipelined restoring divider, one quotient bit per stage
module x2luv_div #(
    parameter int NW = 38,
    parameter int DW = 23,
    parameter int QW = 21
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num_i,
    input  logic [DW-1:0] den_i,
    output logic [QW-1:0] quo_o
);

    logic [DW-1:0] rem_reg  [0:QW-1];
    logic [NW-1:0] num_reg  [0:QW-1];
    logic [DW-1:0] den_reg  [0:QW-1];
    logic [QW-1:0] quo_reg  [0:QW-1];
    logic [DW-1:0] rem_next [0:QW-1];
    logic [QW-1:0] quo_next [0:QW-1];

    // one compare and subtract per stage
    always_comb begin
        logic [DW-1:0] rem_in;
        logic [NW-1:0] num_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [DW:0]   trial;
        for (int s = 0; s < QW; s++) begin
            if (s == 0) begin
                rem_in = DW'(num_i[NW-1:QW]);
                num_in = num_i;
                den_in = den_i;
                quo_in = '0;
            end else begin
                rem_in = rem_reg[s-1];
                num_in = num_reg[s-1];
                den_in = den_reg[s-1];
                quo_in = quo_reg[s-1];
            end
            trial = {rem_in, num_in[QW-1-s]};
            if (trial >= {1'b0, den_in}) begin
                rem_next[s] = DW'(trial - {1'b0, den_in});
                quo_next[s] = {quo_in[QW-2:0], 1'b1};
            end else begin
                rem_next[s] = DW'(trial);
                quo_next[s] = {quo_in[QW-2:0], 1'b0};
            end
        end
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < QW; s++) begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                if (s == 0) begin
                    num_reg[s] <= num_i;
                    den_reg[s] <= den_i;
                end else begin
                    num_reg[s] <= num_reg[s-1];
                    den_reg[s] <= den_reg[s-1];
                end
            end
        end
    end

    assign quo_o = quo_reg[QW-1];

endmodule

[src/x2luv_light.sv]
// lightness pipeline: digit-by-digit cube root plus linear segment
module x2luv_light (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [x2luv_pkg::XW-1:0] y_i,
    output logic [x2luv_pkg::LW-1:0] light_o
);
    import x2luv_pkg::*;

    localparam int N   = CBRT_STAGES;
    localparam int RTW = N;
    localparam int SQW = 2 * N;
    localparam int RMW = SQW + 5;
    localparam int TW  = 3 * N;

    logic [RTW-1:0] root_reg [0:N-1];
    logic [SQW-1:0] sq_reg   [0:N-1];
    logic [RMW-1:0] rem_reg  [0:N-1];
    logic [XW-1:0]  y_reg    [0:N-1];
    logic [RTW-1:0] root_next [0:N-1];
    logic [SQW-1:0] sq_next   [0:N-1];
    logic [RMW-1:0] rem_next  [0:N-1];

    // one three-bit group of y * 2^44 per stage
    always_comb begin
        logic [RTW-1:0] root_in;
        logic [SQW-1:0] sq_in;
        logic [RMW-1:0] rem_in;
        logic [XW-1:0]  y_in;
        logic [TW-1:0]  t;
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        for (int s = 0; s < N; s++) begin
            if (s == 0) begin
                root_in = '0;
                sq_in   = '0;
                rem_in  = '0;
                y_in    = y_i;
            end else begin
                root_in = root_reg[s-1];
                sq_in   = sq_reg[s-1];
                rem_in  = rem_reg[s-1];
                y_in    = y_reg[s-1];
            end
            t      = TW'({y_in, 44'd0});
            rem_sh = {rem_in[RMW-4:0], t[TW-1-3*s -: 3]};
            trial  = (RMW'(sq_in) << 3) + (RMW'(sq_in) << 2)
                   + (RMW'(root_in) << 2) + (RMW'(root_in) << 1) + RMW'(1);
            if (rem_sh >= trial) begin
                rem_next[s]  = rem_sh - trial;
                root_next[s] = {root_in[RTW-2:0], 1'b1};
                sq_next[s]   = (sq_in << 2) + (SQW'(root_in) << 2) + SQW'(1);
            end else begin
                rem_next[s]  = rem_sh;
                root_next[s] = {root_in[RTW-2:0], 1'b0};
                sq_next[s]   = sq_in << 2;
            end
        end
    end

    // cube root stage registers
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < N; s++) begin
                root_reg[s] <= root_next[s];
                sq_reg[s]   <= sq_next[s];
                rem_reg[s]  <= rem_next[s];
                if (s == 0) begin
                    y_reg[s] <= y_i;
                end else begin
                    y_reg[s] <= y_reg[s-1];
                end
            end
        end
    end

    // scale the root and start the linear segment
    logic [27:0] scaled;
    logic [27:0] shifted;
    logic [32:0] lin_num;
    logic [16:0] cube_next, cube_reg;
    logic [15:0] lin_m_next, lin_m_reg;
    logic        above_next, above_reg;

    always_comb begin
        scaled     = 28'(root_reg[N-1]) * 28'd116;
        shifted    = (scaled > L_OFF) ? scaled - L_OFF : 28'd0;
        cube_next  = 17'((29'(shifted) + 29'd2048) >> 12);
        lin_num    = 33'(y_reg[N-1]) * LIN_MUL + LIN_RND;
        lin_m_next = lin_num[23:8];
        above_next = (33'(y_reg[N-1]) * LIN_MUL) > LIN_THRESH;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cube_reg  <= cube_next;
            lin_m_reg <= lin_m_next;
            above_reg <= above_next;
        end
    end

    // divide by 27 through the reciprocal and pick the branch
    logic [32:0] lin_prod;
    logic [15:0] light_next, light_reg;

    always_comb begin
        lin_prod = 33'(lin_m_reg) * 33'(RECIP27);
        if (above_reg) begin
            light_next = cube_reg[16] ? 16'hFFFF : cube_reg[15:0];
        end else begin
            light_next = 16'(lin_prod >> RECIP27_SH);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            light_reg <= light_next;
        end
    end

    assign light_o = light_reg;

endmodule

[src/x2luv_star.sv]
// opponent coordinates u* and v*, saturation and result assembly
module x2luv_star (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [x2luv_pkg::LW-1:0]     light_i,
    input  logic [x2luv_pkg::DIV_QW-1:0] uq_i,
    input  logic [x2luv_pkg::DIV_QW-1:0] vq_i,
    input  logic                         dz_i,
    output x2luv_pkg::luv_t              res_o
);
    import x2luv_pkg::*;

    // stage 1: offset from the white point as sign and magnitude
    logic [25:0] u19, v19;
    logic [25:0] umag_next, vmag_next;
    logic        uneg_next, vneg_next;
    logic [PW-1:0] usat_next, vsat_next;

    always_comb begin
        u19 = (26'(uq_i) << 4) + (26'(uq_i) << 1) + 26'(uq_i);
        v19 = (26'(vq_i) << 4) + (26'(vq_i) << 1) + 26'(vq_i);
        uneg_next = u19 < WHITE_U;
        vneg_next = v19 < WHITE_V;
        umag_next = uneg_next ? WHITE_U - u19 : u19 - WHITE_U;
        vmag_next = vneg_next ? WHITE_V - v19 : v19 - WHITE_V;
        usat_next = (uq_i > DIV_QW'(18'h3FFFF)) ? 18'h3FFFF : uq_i[PW-1:0];
        vsat_next = (vq_i > DIV_QW'(18'h3FFFF)) ? 18'h3FFFF : vq_i[PW-1:0];
    end

    logic [LW-1:0] l1_reg;
    logic [25:0]   umag1_reg, vmag1_reg;
    logic          uneg_reg [0:STAR_LAT-1];
    logic          vneg_reg [0:STAR_LAT-1];
    logic          dz_reg   [0:STAR_LAT-1];
    logic [PW-1:0] usat_reg [0:STAR_LAT-1];
    logic [PW-1:0] vsat_reg [0:STAR_LAT-1];
    logic [LW-1:0] l_reg    [0:STAR_LAT-1];

    // stage 2 to 4 values
    logic [41:0] uprod_reg, vprod_reg;
    logic [45:0] un_full, vn_full;
    logic [29:0] um_reg, vm_reg;
    logic [58:0] uq_full, vq_full;
    logic [25:0] uq4_reg, vq4_reg;

    always_comb begin
        un_full = 46'(uprod_reg) * 46'd13 + STAR_RND;
        vn_full = 46'(vprod_reg) * 46'd13 + STAR_RND;
        uq_full = 59'(um_reg) * 59'(RECIP19);
        vq_full = 59'(vm_reg) * 59'(RECIP19);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            l1_reg      <= light_i;
            umag1_reg   <= umag_next;
            vmag1_reg   <= vmag_next;
            uneg_reg[0] <= uneg_next;
            vneg_reg[0] <= vneg_next;
            dz_reg[0]   <= dz_i;
            usat_reg[0] <= usat_next;
            vsat_reg[0] <= vsat_next;
            l_reg[0]    <= light_i;
            // stage 2: lightness times offset
            uprod_reg <= 42'(l1_reg) * 42'(umag1_reg);
            vprod_reg <= 42'(l1_reg) * 42'(vmag1_reg);
            // stage 3: times 13, round, drop the power of two
            um_reg <= un_full[45:16];
            vm_reg <= vn_full[45:16];
            // stage 4: divide by 19 through the reciprocal
            uq4_reg <= 26'(uq_full >> RECIP19_SH);
            vq4_reg <= 26'(vq_full >> RECIP19_SH);
            // side values ride along
            for (int s = 1; s < STAR_LAT; s++) begin
                dz_reg[s]   <= dz_reg[s-1];
                usat_reg[s] <= usat_reg[s-1];
                vsat_reg[s] <= vsat_reg[s-1];
                l_reg[s]    <= l_reg[s-1];
                uneg_reg[s] <= uneg_reg[s-1];
                vneg_reg[s] <= vneg_reg[s-1];
            end
        end
    end

    // saturate, apply sign and clear chromaticity on a zero denominator
    logic          uneg4, vneg4;
    logic [SW-1:0] us, vs;

    assign uneg4 = uneg_reg[STAR_LAT-1];
    assign vneg4 = vneg_reg[STAR_LAT-1];

    always_comb begin
        if (uneg4) begin
            us = (uq4_reg > STAR_NEG) ? {1'b1, {(SW-1){1'b0}}} : SW'(-uq4_reg);
        end else begin
            us = (uq4_reg > STAR_POS) ? {1'b0, {(SW-1){1'b1}}} : SW'(uq4_reg);
        end
        if (vneg4) begin
            vs = (vq4_reg > STAR_NEG) ? {1'b1, {(SW-1){1'b0}}} : SW'(-vq4_reg);
        end else begin
            vs = (vq4_reg > STAR_POS) ? {1'b0, {(SW-1){1'b1}}} : SW'(vq4_reg);
        end
        res_o.lightness  = l_reg[STAR_LAT-1];
        res_o.denom_zero = dz_reg[STAR_LAT-1];
        if (dz_reg[STAR_LAT-1]) begin
            res_o.u_prime = '0;
            res_o.v_prime = '0;
            res_o.u_star  = '0;
            res_o.v_star  = '0;
        end else begin
            res_o.u_prime = usat_reg[STAR_LAT-1];
            res_o.v_prime = vsat_reg[STAR_LAT-1];
            res_o.u_star  = us;
            res_o.v_star  = vs;
        end
    end

endmodule

[src/xyz_to_cieluv.sv]
// Converts one CIE XYZ sample (unsigned Q2.16) per clock into CIELUV: L* in
// Q8.8, u' and v' in Q2.16 and u*, v* in signed Q14.8, against the
// equal-energy white point with Y taken as given. A request is taken in every
// cycle in which the result side is not stalled, so the sustained rate is one
// sample per cycle; a stall on m_tready freezes the whole pipeline. A sample
// passes through the 21 stages of the bit-serial cube root, two stages of
// lightness scaling, four stages of opponent arithmetic and the output
// register. The two chromaticity dividers run in parallel with the cube root.
// When X, Y and Z are all zero, m_tuser is raised and u', v', u* and v* are
// zero.
module xyz_to_cieluv (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // x_val, y_val, z_val, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // lightness, u_prime, v_prime, u_star, v_star, zero pad
    output logic [0:0]   m_tuser    // denom_zero
);
    import x2luv_pkg::*;

    logic            en;
    logic [XW-1:0]   x_val, y_val, z_val;
    logic [DEN_W-1:0] denom;
    logic [NUM_W-1:0] num_u, num_v;
    logic [DIV_QW-1:0] uq, vq;
    logic [LW-1:0]   light;
    luv_t            res;

    // pipeline moves whenever the output register can take a request
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // unpack and form numerators and denominator
    assign x_val = s_tdata[17:0];
    assign y_val = s_tdata[35:18];
    assign z_val = s_tdata[53:36];

    always_comb begin
        denom = DEN_W'(x_val) + (DEN_W'(y_val) << 4) - DEN_W'(y_val)
              + (DEN_W'(z_val) << 1) + DEN_W'(z_val);
        num_u = (NUM_W'(x_val) << 18) + NUM_W'(denom[DEN_W-1:1]);
        num_v = (NUM_W'(y_val) << 19) + (NUM_W'(y_val) << 16)
              + NUM_W'(denom[DEN_W-1:1]);
    end

    x2luv_div #(.NW(NUM_W), .DW(DEN_W), .QW(DIV_QW)) u_div_u (
        .aclk  (aclk),
        .en    (en),
        .num_i (num_u),
        .den_i (denom),
        .quo_o (uq)
    );

    x2luv_div #(.NW(NUM_W), .DW(DEN_W), .QW(DIV_QW)) u_div_v (
        .aclk  (aclk),
        .en    (en),
        .num_i (num_v),
        .den_i (denom),
        .quo_o (vq)
    );

    x2luv_light u_light (
        .aclk    (aclk),
        .en      (en),
        .y_i     (y_val),
        .light_o (light)
    );

    // align quotients and the zero flag with the lightness
    logic [DIV_QW-1:0] uq_dly_reg [0:DIV_EXTRA-1];
    logic [DIV_QW-1:0] vq_dly_reg [0:DIV_EXTRA-1];
    logic              dz_dly_reg [0:LIGHT_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            uq_dly_reg[0] <= uq;
            vq_dly_reg[0] <= vq;
            dz_dly_reg[0] <= (denom == '0);
            for (int s = 1; s < DIV_EXTRA; s++) begin
                uq_dly_reg[s] <= uq_dly_reg[s-1];
                vq_dly_reg[s] <= vq_dly_reg[s-1];
            end
            for (int s = 1; s < LIGHT_LAT; s++) begin
                dz_dly_reg[s] <= dz_dly_reg[s-1];
            end
        end
    end

    x2luv_star u_star (
        .aclk    (aclk),
        .en      (en),
        .light_i (light),
        .uq_i    (uq_dly_reg[DIV_EXTRA-1]),
        .vq_i    (vq_dly_reg[DIV_EXTRA-1]),
        .dz_i    (dz_dly_reg[LIGHT_LAT-1]),
        .res_o   (res)
    );

    // valid bits travel with the data
    logic vld_reg [0:PIPE_LAT-1];
    logic out_vld_reg;
    luv_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < PIPE_LAT; s++) begin
                vld_reg[s] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int s = 1; s < PIPE_LAT; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
            out_vld_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_reg.v_star, out_reg.u_star, out_reg.v_prime,
                       out_reg.u_prime, out_reg.lightness};
    assign m_tuser  = out_reg.denom_zero;

endmodule

[tb/xyz_to_cieluv_tb.sv]
// testbench for the xyz to cieluv converter: random and corner samples checked against a predictor
`timescale 1ns / 1ps

module xyz_to_cieluv_tb;
    import x2luv_pkg::*;

    localparam int WATCH_LIMIT = 20000;

    // expected conversion of one sample
    typedef struct {
        logic [15:0] lightness;
        logic [17:0] u_prime;
        logic [17:0] v_prime;
        logic [22:0] u_star;
        logic [22:0] v_star;
        logic        denom_zero;
    } luv_exp_t;

    // floor cube root by bisection
    function automatic longint unsigned cube_root(longint unsigned t);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = (64'd1 << 21) - 1;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid * mid <= t) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // lightness in q8.8 from y
    function automatic longint unsigned luminance_to_lstar(longint unsigned y);
        longint unsigned l, v, r;
        if (y * 24389 > 216 * 65536) begin
            r = cube_root(y << 44);
            v = 116 * r;
            v = (v > (64'd16 << 20)) ? v - (64'd16 << 20) : 0;
            l = (v + 2048) >> 12;
        end else begin
            l = (24389 * y + 3456) / 6912;
        end
        return (l > 65535) ? 65535 : l;
    endfunction

    // opponent coordinate, rounded to nearest with ties away from zero, and clamped
    function automatic logic [22:0] opponent_term(longint unsigned l, longint diff);
        logic neg;
        longint unsigned mag, q;
        longint s;
        neg = diff < 0;
        mag = neg ? longint'(-diff) : diff;
        q = (13 * l * mag + 622592) / 1245184;
        if (neg) s = (q > 4194304) ? -4194304 : -longint'(q);
        else s = (q > 4194303) ? 4194303 : longint'(q);
        return s[22:0];
    endfunction

    function automatic luv_exp_t convert_xyz(logic [17:0] xv, logic [17:0] yv, logic [17:0] zv);
        luv_exp_t e;
        longint unsigned x, y, z, d, uq, vq, l;
        x = xv;
        y = yv;
        z = zv;
        d = x + 15 * y + 3 * z;
        l = luminance_to_lstar(y);
        e.lightness = l[15:0];
        if (d == 0) begin
            e.u_prime = 0;
            e.v_prime = 0;
            e.u_star = 0;
            e.v_star = 0;
            e.denom_zero = 1'b1;
        end else begin
            uq = ((x << 18) + (d >> 1)) / d;
            vq = (9 * (y << 16) + (d >> 1)) / d;
            e.u_prime = (uq > 262143) ? 18'h3FFFF : uq[17:0];
            e.v_prime = (vq > 262143) ? 18'h3FFFF : vq[17:0];
            e.u_star = opponent_term(l, longint'(19 * uq) - 262144);
            e.v_star = opponent_term(l, longint'(19 * vq) - 589824);
            e.denom_zero = 1'b0;
        end
        return e;
    endfunction

    // holds pending conversions and compares results
    class luv_scoreboard;
        luv_exp_t pending[$];
        int errors = 0;

        function void note_request(logic [55:0] data);
            pending = {pending, convert_xyz(data[17:0], data[35:18], data[53:36])};
        endfunction

        function void check_result(logic [103:0] data, logic flag);
            luv_exp_t e;
            if (pending.size() == 0) begin
                $error("result with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[15:0] !== e.lightness) begin
                $error("lightness exp %0d got %0d", e.lightness, data[15:0]); errors++;
            end
            if (data[33:16] !== e.u_prime) begin
                $error("u_prime exp %0d got %0d", e.u_prime, data[33:16]); errors++;
            end
            if (data[51:34] !== e.v_prime) begin
                $error("v_prime exp %0d got %0d", e.v_prime, data[51:34]); errors++;
            end
            if (data[74:52] !== e.u_star) begin
                $error("u_star exp %0d got %0d", $signed(e.u_star), $signed(data[74:52]));
                errors++;
            end
            if (data[97:75] !== e.v_star) begin
                $error("v_star exp %0d got %0d", $signed(e.v_star), $signed(data[97:75]));
                errors++;
            end
            if (flag !== e.denom_zero) begin
                $error("denom_zero exp %0d got %0d", e.denom_zero, flag); errors++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [55:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [0:0]   m_tuser;

    luv_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    bit hold_off = 1'b0;
    bit done = 1'b0;
    int quiet = 0;

    xyz_to_cieluv dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: random stall, long hold while hold_off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
        m_tready <= aresetn && !hold_off && ($urandom_range(99) >= recv_idle);
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else if (aresetn && !done) quiet <= quiet + 1;
        if (quiet >= WATCH_LIMIT) begin
            $display("[xyz_to_cieluv] ERROR");
            $finish;
        end
    end

    // offer one sample and wait for its acceptance
    task automatic send_sample(logic [17:0] xv, logic [17:0] yv, logic [17:0] zv);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, zv, yv, xv};
        do @(posedge aclk); while (!s_tready);
        sb.note_request({2'b00, zv, yv, xv});
    endtask

    // one of four kinds at random: full range, small y near the threshold, tiny values or moderate values
    task automatic send_random(int n);
        logic [17:0] a, b, c;
        repeat (n) begin
            case ($urandom_range(3))
                0: begin a = 18'($urandom); b = 18'($urandom); c = 18'($urandom); end
                1: begin a = 18'($urandom_range(70000)); b = 18'($urandom_range(600));
                    c = 18'($urandom_range(70000)); end
                2: begin a = 18'($urandom_range(3)); b = 18'($urandom_range(3));
                    c = 18'($urandom_range(3)); end
                default: begin a = 18'($urandom_range(80000)); b = 18'($urandom_range(80000));
                    c = 18'($urandom_range(90000)); end
            endcase
            send_sample(a, b, c);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // corner samples: zero, full scale, pure components, threshold edges
        send_sample(0, 0, 0);
        send_sample(18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
        send_sample(18'h3FFFF, 0, 0);
        send_sample(0, 18'h3FFFF, 0);
        send_sample(0, 0, 18'h3FFFF);
        send_sample(1, 0, 0);
        send_sample(0, 1, 0);
        send_sample(0, 0, 1);
        send_sample(0, 580, 0);
        send_sample(0, 581, 0);
        send_sample(1000, 580, 2000);
        send_sample(62259, 65536, 71362);
        send_sample(65536, 65536, 65536);
        send_sample(18'h2AAAA, 18'h15555, 18'h2AAAA);
        send_sample(18'h15555, 18'h2AAAA, 18'h15555);
        send_sample(1, 18'h3FFFF, 1);
        send_sample(18'h3FFFF, 1, 18'h3FFFF);
        // phase one: sender light idling, receiver heavy
        send_idle = 33; recv_idle = 87;
        send_random(130);
        // long receiver hold while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
            send_random(60);
        join
        send_idle = 87; recv_idle = 33;
        send_random(100);
        send_idle = 0; recv_idle = 0;
        send_random(110);
        s_tvalid <= 1'b0;
        done = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        @(posedge aclk);
        done = 1'b1;
        repeat (60) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0 && !m_tvalid)
            $display("[xyz_to_cieluv] OK");
        else
            $display("[xyz_to_cieluv] ERROR");
        $finish;
    end

    // a result after everything was checked is a failure
    always @(posedge aclk) begin
        if (done && m_tvalid && m_tready) begin
            $error("unexpected late result");
            sb.errors++;
        end
    end

endmodule
